### rtl/spm_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the spiral-order matrix reader.
// No dependencies; imported by every module of the block.
package spm_pkg;

  localparam int unsigned MAX_DIM     = 64;
  localparam int unsigned DATA_WIDTH  = 32;
  localparam int unsigned DIM_W       = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W      = 2 * DIM_W;
  localparam int unsigned STORE_DEPTH = MAX_DIM * MAX_DIM;
  localparam int unsigned CNT_W       = $clog2(STORE_DEPTH + 1);
  localparam int unsigned CFG_W       = 7;
  localparam int unsigned CFG_IDX_W   = 2;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_READ  = 2'd1,
    ST_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    DIR_RIGHT = 2'd0,
    DIR_DOWN  = 2'd1,
    DIR_LEFT  = 2'd2,
    DIR_UP    = 2'd3
  } dir_e;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_COLS = CFG_IDX_W'(1);

  // Write and read request toward the element store
  typedef struct packed {
    logic                  we;
    logic [ADDR_W-1:0]     waddr;
    logic [DATA_WIDTH-1:0] wdata;
    logic [ADDR_W-1:0]     raddr;
  } mem_req_t;

  // Result control, produced in the cycle before the store read data
  typedef struct packed {
    logic    valid;
    logic    last;
    status_e status;
  } rsp_t;

  // Clamp a register value to the usable dimension range 1..MAX_DIM
  function automatic logic [DIM_W:0] eff_dim(logic [CFG_W-1:0] v);
    logic [DIM_W:0] r;
    if (v == '0) begin
      r = (DIM_W+1)'(1);
    end else if (v > CFG_W'(MAX_DIM)) begin
      r = (DIM_W+1)'(MAX_DIM);
    end else begin
      r = (DIM_W+1)'(v);
    end
    return r;
  endfunction

endpackage

### rtl/spm_store.sv
`timescale 1ns / 1ps
// Element store: one write port, one read port, registered read data.
// Depends on spm_pkg.
module spm_store
  import spm_pkg::*;
(
  input  logic                  clk_i,
  input  mem_req_t              req_i,
  output logic [DATA_WIDTH-1:0] rdata_o
);

  logic [DATA_WIDTH-1:0] mem_q [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/spm_ctrl.sv
`timescale 1ns / 1ps
// Load counters, spiral walker and configuration registers.
// Depends on spm_pkg; drives the element store request and result control.
module spm_ctrl
  import spm_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  take_i,
  input  logic                  cmd_i,
  input  logic [DATA_WIDTH-1:0] value_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_W-1:0]      cfg_wdata_i,
  output mem_req_t              req_o,
  output rsp_t                  rsp_o
);

  logic [CFG_W-1:0] rows_q, rows_d, cols_q, cols_d;
  logic [CNT_W-1:0] load_cnt_q, load_cnt_d, emit_cnt_q, emit_cnt_d;
  logic [DIM_W-1:0] ld_row_q, ld_row_d, ld_col_q, ld_col_d;
  logic [DIM_W-1:0] cur_row_q, cur_row_d, cur_col_q, cur_col_d;
  logic [DIM_W-1:0] top_q, top_d, left_q, left_d;
  logic [DIM_W:0]   bottom_q, bottom_d, right_q, right_d;
  dir_e             dir_q, dir_d;

  logic [DIM_W:0]   nr, nc;
  logic [CNT_W-1:0] total;
  logic             loaded, read_ok, last;

  assign nr     = eff_dim(rows_q);
  assign nc     = eff_dim(cols_q);
  assign total  = CNT_W'(nr) * CNT_W'(nc);
  assign loaded = (load_cnt_q == total);
  assign read_ok = loaded && (emit_cnt_q < total);
  assign last   = ((emit_cnt_q + CNT_W'(1)) == total);

  always_comb begin
    rows_d     = rows_q;
    cols_d     = cols_q;
    load_cnt_d = load_cnt_q;
    emit_cnt_d = emit_cnt_q;
    ld_row_d   = ld_row_q;
    ld_col_d   = ld_col_q;
    cur_row_d  = cur_row_q;
    cur_col_d  = cur_col_q;
    top_d      = top_q;
    left_d     = left_q;
    bottom_d   = bottom_q;
    right_d    = right_q;
    dir_d      = dir_q;

    req_o.we    = 1'b0;
    req_o.waddr = {ld_row_q, ld_col_q};
    req_o.wdata = value_i;
    req_o.raddr = {cur_row_q, cur_col_q};

    rsp_o.valid  = 1'b0;
    rsp_o.last   = 1'b0;
    rsp_o.status = ST_OK;

    if (cfg_we_i && (cfg_idx_i == REG_ROWS || cfg_idx_i == REG_COLS)) begin
      if (cfg_idx_i == REG_ROWS) rows_d = cfg_wdata_i;
      else                       cols_d = cfg_wdata_i;
      // Restart loading and the walk with the new shape
      load_cnt_d = '0;
      emit_cnt_d = '0;
      ld_row_d   = '0;
      ld_col_d   = '0;
      cur_row_d  = '0;
      cur_col_d  = '0;
      top_d      = '0;
      left_d     = '0;
      bottom_d   = eff_dim(rows_d) - (DIM_W+1)'(1);
      right_d    = eff_dim(cols_d) - (DIM_W+1)'(1);
      dir_d      = DIR_RIGHT;
    end else if (take_i) begin
      if (cmd_i == CMD_LOAD) begin
        if (load_cnt_q < total) begin
          req_o.we   = 1'b1;
          load_cnt_d = load_cnt_q + CNT_W'(1);
          if (({1'b0, ld_col_q} + (DIM_W+1)'(1)) == nc) begin
            ld_col_d = '0;
            ld_row_d = ld_row_q + DIM_W'(1);
          end else begin
            ld_col_d = ld_col_q + DIM_W'(1);
          end
        end else begin
          rsp_o.valid  = 1'b1;
          rsp_o.status = ST_OVERFLOW;
        end
      end else begin
        rsp_o.valid = 1'b1;
        if (!read_ok) begin
          rsp_o.status = ST_NO_READ;
        end else begin
          rsp_o.last = last;
          emit_cnt_d = emit_cnt_q + CNT_W'(1);
          if (!last) begin
            unique case (dir_q)
              DIR_RIGHT: begin
                if ({1'b0, cur_col_q} < right_q) begin
                  cur_col_d = cur_col_q + DIM_W'(1);
                end else begin
                  top_d     = top_q + DIM_W'(1);
                  dir_d     = DIR_DOWN;
                  cur_row_d = cur_row_q + DIM_W'(1);
                end
              end
              DIR_DOWN: begin
                if ({1'b0, cur_row_q} < bottom_q) begin
                  cur_row_d = cur_row_q + DIM_W'(1);
                end else begin
                  right_d   = right_q - (DIM_W+1)'(1);
                  dir_d     = DIR_LEFT;
                  cur_col_d = cur_col_q - DIM_W'(1);
                end
              end
              DIR_LEFT: begin
                if (cur_col_q > left_q) begin
                  cur_col_d = cur_col_q - DIM_W'(1);
                end else begin
                  bottom_d  = bottom_q - (DIM_W+1)'(1);
                  dir_d     = DIR_UP;
                  cur_row_d = cur_row_q - DIM_W'(1);
                end
              end
              default: begin
                if (cur_row_q > top_q) begin
                  cur_row_d = cur_row_q - DIM_W'(1);
                end else begin
                  left_d    = left_q + DIM_W'(1);
                  dir_d     = DIR_RIGHT;
                  cur_col_d = cur_col_q + DIM_W'(1);
                end
              end
            endcase
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q     <= CFG_W'(1);
      cols_q     <= CFG_W'(1);
      load_cnt_q <= '0;
      emit_cnt_q <= '0;
      ld_row_q   <= '0;
      ld_col_q   <= '0;
      cur_row_q  <= '0;
      cur_col_q  <= '0;
      top_q      <= '0;
      left_q     <= '0;
      bottom_q   <= '0;
      right_q    <= '0;
      dir_q      <= DIR_RIGHT;
    end else begin
      rows_q     <= rows_d;
      cols_q     <= cols_d;
      load_cnt_q <= load_cnt_d;
      emit_cnt_q <= emit_cnt_d;
      ld_row_q   <= ld_row_d;
      ld_col_q   <= ld_col_d;
      cur_row_q  <= cur_row_d;
      cur_col_q  <= cur_col_d;
      top_q      <= top_d;
      left_q     <= left_d;
      bottom_q   <= bottom_d;
      right_q    <= right_d;
      dir_q      <= dir_d;
    end
  end

endmodule

### rtl/spiral_order_matrix_reader_unit.sv
`timescale 1ns / 1ps
// Spiral-order matrix reader: loads a matrix row-major, reads it back clockwise.
// A result appears in the cycle after its item is accepted (store read port).
// Throughput: one item per cycle; busy stays low, loads and reads never stall.
// Reset: asynchronous, active low; clears counters and walk state, sets 1x1 shape.
// Store contents have no reset. The receiver cannot stall; valid_o is a strobe.
// Depends on spm_pkg, spm_ctrl, spm_store.
module spiral_order_matrix_reader_unit
  import spm_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  logic                         cmd_i,
  input  logic signed [DATA_WIDTH-1:0] value_i,
  input  logic                         cfg_we_i,
  input  logic [CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [CFG_W-1:0]             cfg_wdata_i,
  output logic                         valid_o,
  output logic signed [DATA_WIDTH-1:0] data_o,
  output logic                         last_o,
  output logic [1:0]                   status_o
);

  mem_req_t              req;
  rsp_t                  rsp, rsp_q;
  logic [DATA_WIDTH-1:0] rdata;
  logic                  take;

  // Every item finishes its state update in the cycle it is taken
  assign busy = 1'b0;
  assign take = start && !busy;

  spm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .cmd_i       (cmd_i),
    .value_i     (value_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_o       (req),
    .rsp_o       (rsp)
  );

  spm_store u_store (
    .clk_i   (clk_i),
    .req_i   (req),
    .rdata_o (rdata)
  );

  // Register the result control so it lines up with the registered read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_q <= '{valid: 1'b0, last: 1'b0, status: ST_OK};
    end else begin
      rsp_q <= rsp;
    end
  end

  assign valid_o  = rsp_q.valid;
  assign last_o   = rsp_q.last;
  assign status_o = rsp_q.status;
  // Drop the read data on any error result
  assign data_o   = (rsp_q.valid && rsp_q.status == ST_OK) ? $signed(rdata) : '0;

  // A read item taken without a configuration write always produces a result on the next cycle
  a_read_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && cmd_i == CMD_READ && !cfg_we_i) |=> valid_o)
    else $error("read item produced no result");

  // Last is only flagged on a good read result
  a_last_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_o |-> (valid_o && status_o == ST_OK))
    else $error("last flagged on a non-ok or missing result");

  // Error results carry zero data
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && status_o != ST_OK) |-> (data_o == '0))
    else $error("error result carries data");

  // No result appears without an item taken the cycle before
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(take))
    else $error("result without an item");

endmodule
